// ----- sv/kbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard encoder package
// Shared widths, key set type and the constant tables used by the character
// picker and the edge encoders.
// ----------------------------------------------------------------------------
package kbe_pkg;

	localparam int TIME_BITS     = 32;
	localparam int GAP_BITS      = 16;
	localparam int IN_DATA_BITS  = 96;
	localparam int OUT_DATA_BITS = 24;

	localparam logic [GAP_BITS-1:0] GAP_RESET = 16'd100;

	// Key codes of the event encoders.
	localparam logic [5:0] CODE_DIGIT_BASE = 6'd0;
	localparam logic [5:0] CODE_EDIT_BASE  = 6'd10;
	localparam logic [5:0] CODE_FUNC_BASE  = 6'd14;
	localparam logic [5:0] CODE_ALPHA_BASE = 6'd29;
	localparam logic [5:0] CODE_PAUSE      = 6'd55;

	localparam logic [6:0] ASCII_SPACE = 7'd32;
	localparam logic [6:0] ASCII_MINUS = 7'd45;
	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_UPPER = 7'd65;
	localparam logic [6:0] ASCII_LOWER = 7'd97;

	typedef struct packed {
		logic [9:0]  digits;
		logic [25:0] letters;
		logic [14:0] funcs;
		logic [4:0]  edits;
		logic        caps;
	} keyset_t;

	typedef logic [4:0] letter_idx_t;

	// Letters in typing priority order (QWERTY rows), index 0 is A.
	localparam letter_idx_t TYPE_ORDER [26] = '{
		5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14,
		5'd15, 5'd0,  5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10,
		5'd11, 5'd25, 5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12
	};

	// Letters in event scan order: A..P, R..V, Y, Z, Q, X, W.
	localparam letter_idx_t EVENT_ORDER [26] = '{
		5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
		5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd17, 5'd18,
		5'd19, 5'd20, 5'd21, 5'd24, 5'd25, 5'd16, 5'd23, 5'd22
	};

	// Shifted digits on the Turkish layout: = ! ' ^ + % & / ( )
	localparam logic [6:0] SHIFTED_DIGIT [10] = '{
		7'd61, 7'd33, 7'd39, 7'd94, 7'd43, 7'd37, 7'd38, 7'd47, 7'd40, 7'd41
	};

endpackage

// ----- sv/keyboard_state_to_char_and_key_events_unit.sv -----
`timescale 1ns / 1ps
// Path: each accepted transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle while m_tready is high; the snapshot state is
// updated in the same cycle as the result register is loaded, so items follow back to back.
// A held result stalls the input only once the input register is also full.
// Reset: arst_n clears the stage valids, caps lock, the previous snapshot and
// the last typed time, and loads the repeat gap with 100 ticks.
// ----------------------------------------------------------------------------
// Keyboard state to character and key events
// Input register, short character/edge logic and a result register, with the
// previous snapshot, caps lock flag and repeat timer held between items.
// ----------------------------------------------------------------------------
module keyboard_state_to_char_and_key_events_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [15:0]                       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// digit_keys[9:0], letter_keys[35:10], function_keys[50:36], edit_keys[55:51],
	// space_key[56], minus_key[57], left_shift[58], right_shift[59], caps_key[60],
	// time_now[92:61], zero fill[95:93]
	input  logic [kbe_pkg::IN_DATA_BITS-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// char_valid[0], typed_char[7:1], press_valid[8], press_code[14:9],
	// release_valid[15], release_code[21:16], zero fill[23:22]
	output logic [kbe_pkg::OUT_DATA_BITS-1:0] m_tdata
);

	logic                            valid_s1;
	kbe_pkg::keyset_t                keys_s1;
	logic                            space_s1;
	logic                            minus_s1;
	logic                            shift_s1;
	logic [kbe_pkg::TIME_BITS-1:0]   time_s1;

	logic [kbe_pkg::GAP_BITS-1:0]    gap_q;
	kbe_pkg::keyset_t                prev_keys_q;
	logic                            caps_active_q;
	logic [kbe_pkg::TIME_BITS-1:0]   last_time_q;

	logic                            valid_s2;
	logic [kbe_pkg::OUT_DATA_BITS-1:0] data_s2;

	logic                            advance;
	logic                            caps_next;
	logic                            upper;
	logic                            char_found;
	logic [6:0]                      char_code;
	logic [kbe_pkg::TIME_BITS-1:0]   elapsed;
	logic                            char_ok;
	logic                            press_hit;
	logic [5:0]                      press_code;
	logic                            release_hit;
	logic [5:0]                      release_code;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= kbe_pkg::GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			keys_s1.digits  <= s_tdata[9:0];
			keys_s1.letters <= s_tdata[35:10];
			keys_s1.funcs   <= s_tdata[50:36];
			keys_s1.edits   <= s_tdata[55:51];
			space_s1        <= s_tdata[56];
			minus_s1        <= s_tdata[57];
			shift_s1        <= s_tdata[58] | s_tdata[59];
			keys_s1.caps    <= s_tdata[60];
			time_s1         <= s_tdata[92:61];
		end
	end

	// Caps lock toggles on the rising edge of the caps key before the case is chosen.
	assign caps_next = caps_active_q ^ (keys_s1.caps & ~prev_keys_q.caps);
	assign upper     = caps_next ^ shift_s1;

	kbe_char_pick u_char_pick (
		.digits    (keys_s1.digits),
		.letters   (keys_s1.letters),
		.space_key (space_s1),
		.minus_key (minus_s1),
		.shift     (shift_s1),
		.upper     (upper),
		.found     (char_found),
		.ch        (char_code)
	);

	assign elapsed = time_s1 - last_time_q;
	assign char_ok = char_found && (elapsed > kbe_pkg::TIME_BITS'(gap_q));

	kbe_edge_enc u_press_enc (
		.now_keys (keys_s1),
		.old_keys (prev_keys_q),
		.hit      (press_hit),
		.code     (press_code)
	);

	kbe_edge_enc u_release_enc (
		.now_keys (prev_keys_q),
		.old_keys (keys_s1),
		.hit      (release_hit),
		.code     (release_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q   <= '0;
			caps_active_q <= 1'b0;
			last_time_q   <= '0;
		end else if (advance) begin
			prev_keys_q   <= keys_s1;
			caps_active_q <= caps_next;
			if (char_ok) begin
				last_time_q <= time_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {2'b00,
			            release_hit ? release_code : 6'd0, release_hit,
			            press_hit ? press_code : 6'd0, press_hit,
			            char_ok ? char_code : 7'd0, char_ok};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// A key cannot both go down and come up between two snapshots.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] && m_tdata[15] |-> m_tdata[14:9] != m_tdata[21:16])
		else $error("press and release report the same key");

	// Every transaction that leaves the input register appears as a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after stage advance");

	// Snapshot state only moves when a transaction is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(caps_active_q) && $stable(prev_keys_q))
		else $error("snapshot state changed without a transaction");

	// The repeat timer is only restarted by a delivered character.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !char_ok |=> $stable(last_time_q))
		else $error("repeat timer moved without a typed character");

endmodule

// ----- sv/kbe_char_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed character picker
// Priority selection of one ASCII character from the letters, space, minus
// and digit keys of a snapshot.
// ----------------------------------------------------------------------------
module kbe_char_pick (
	input  logic [9:0]  digits,
	input  logic [25:0] letters,
	input  logic        space_key,
	input  logic        minus_key,
	input  logic        shift,
	input  logic        upper,
	output logic        found,
	output logic [6:0]  ch
);

	always_comb begin
		found = 1'b0;
		ch    = '0;
		// Lowest priority is assigned first so that later hits override.
		for (int i = 9; i >= 0; i--) begin
			if (digits[i]) begin
				found = 1'b1;
				ch    = shift ? kbe_pkg::SHIFTED_DIGIT[i] : 7'(kbe_pkg::ASCII_ZERO + 7'(i));
			end
		end
		if (!upper) begin
			if (minus_key) begin
				found = 1'b1;
				ch    = kbe_pkg::ASCII_MINUS;
			end
			if (space_key) begin
				found = 1'b1;
				ch    = kbe_pkg::ASCII_SPACE;
			end
		end
		for (int i = 25; i >= 0; i--) begin
			if (letters[kbe_pkg::TYPE_ORDER[i]]) begin
				found = 1'b1;
				ch    = 7'((upper ? kbe_pkg::ASCII_UPPER : kbe_pkg::ASCII_LOWER)
				         + {2'b00, kbe_pkg::TYPE_ORDER[i]});
			end
		end
	end

endmodule

// ----- sv/kbe_edge_enc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key edge encoder
// Finds the first key in scan order that is down in one snapshot and up in
// the other, and gives its key code.
// ----------------------------------------------------------------------------
module kbe_edge_enc (
	input  kbe_pkg::keyset_t now_keys,
	input  kbe_pkg::keyset_t old_keys,
	output logic             hit,
	output logic [5:0]       code
);

	logic [9:0]  d;
	logic [4:0]  e;
	logic [14:0] f;
	logic [25:0] l;

	assign d = now_keys.digits  & ~old_keys.digits;
	assign e = now_keys.edits   & ~old_keys.edits;
	assign f = now_keys.funcs   & ~old_keys.funcs;
	assign l = now_keys.letters & ~old_keys.letters;

	always_comb begin
		hit  = 1'b0;
		code = '0;
		if (e[4]) begin
			hit  = 1'b1;
			code = kbe_pkg::CODE_PAUSE;
		end
		for (int i = 25; i >= 0; i--) begin
			if (l[kbe_pkg::EVENT_ORDER[i]]) begin
				hit  = 1'b1;
				code = 6'(kbe_pkg::CODE_ALPHA_BASE + {1'b0, kbe_pkg::EVENT_ORDER[i]});
			end
		end
		for (int i = 14; i >= 0; i--) begin
			if (f[i]) begin
				hit  = 1'b1;
				code = 6'(kbe_pkg::CODE_FUNC_BASE + 6'(i));
			end
		end
		for (int i = 3; i >= 0; i--) begin
			if (e[i]) begin
				hit  = 1'b1;
				code = 6'(kbe_pkg::CODE_EDIT_BASE + 6'(i));
			end
		end
		for (int i = 9; i >= 0; i--) begin
			if (d[i]) begin
				hit  = 1'b1;
				code = 6'(kbe_pkg::CODE_DIGIT_BASE + 6'(i));
			end
		end
	end

endmodule
